### sv/pefa_pkg.sv
// shared types and constants for the page extent first-fit allocator
// no dependencies; imported by the top level, its checkers and the testbench

package pefa_pkg;

    localparam int ADDR_W   = 52;   // byte address field width
    localparam int PAGES_W  = 40;   // page count field width
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int PAGE_SHIFT = 12;

    localparam logic [63:0] PAGE_BYTES = 64'h1000;
    localparam logic [63:0] PAGE_MASK  = 64'hfff;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_RSVD  = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FULL    = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CALC,
        S_SHIFT,
        S_DONE
    } t_state;

endpackage

### sv/page_extent_first_fit_allocator_unit.sv
// page extent first-fit allocator: extent table in two synchronous memories
// depends on pefa_pkg
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | opcode, address, length_bytes,
//          |           |                           | region_usable, page_count
//  out     | output    | o_out_valid / i_out_ready | result_address, status
//
// add, free and every item answered at once finish in the idle state and go to the output register when it is free
// an allocate walks the table one entry a cycle through the memory read port; when the
// found extent empties, the entries above it are moved down to close the gap
// a miss answers no fit once the last entry has been compared
// reset empties the table at once (entry count cleared), no clearing pass
// a stalled output parks the next finished result and takes no new input until it is passed on

module page_extent_first_fit_allocator_unit #(
    parameter int MAX_EXTENTS = 64,
    parameter int ADDR_BITS   = 52
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pefa_pkg::OP_W-1:0]     i_opcode,
    input  logic [pefa_pkg::ADDR_W-1:0]   i_address,
    input  logic [pefa_pkg::ADDR_W-1:0]   i_length_bytes,
    input  logic                          i_region_usable,
    input  logic [pefa_pkg::PAGES_W-1:0]  i_page_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pefa_pkg::ADDR_W-1:0]   o_result_address,
    output logic [pefa_pkg::STATUS_W-1:0] o_status
);
    import pefa_pkg::*;

    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int FW = ADDR_BITS - PAGE_SHIFT;
    localparam logic [63:0] AddrMask = {64{1'b1}} >> (64 - ADDR_BITS);

    // extent table
    logic [FW-1:0]      mem_frame [MAX_EXTENTS];
    logic [PAGES_W-1:0] mem_pages [MAX_EXTENTS];

    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               we_frame, we_pages;
    logic [IW-1:0]      wr_addr;
    logic [FW-1:0]      wr_frame;
    logic [PAGES_W-1:0] wr_pages;

    logic [FW-1:0]      r_rd_frame;
    logic [PAGES_W-1:0] r_rd_pages;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_total, n_total;
    logic [CW-1:0]      r_idx, n_idx;
    logic [PAGES_W-1:0] r_want, n_want;
    logic [PAGES_W-1:0] r_left, n_left;
    logic [FW-1:0]      r_hit_frame, n_hit_frame;
    logic [IW-1:0]      r_hit_idx, n_hit_idx;
    logic [ADDR_W-1:0]  r_res_addr, n_res_addr;
    t_status            r_res_status, n_res_status;
    logic               r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]  r_out_addr, n_out_addr;
    t_status            r_out_status, n_out_status;

    logic               in_fire, out_free, fin;
    logic [ADDR_W-1:0]  fin_addr;
    t_status            fin_status;

    always_ff @(posedge i_clk) begin
        if (we_frame) mem_frame[wr_addr] <= wr_frame;
        if (we_pages) mem_pages[wr_addr] <= wr_pages;
        if (rd_en) begin
            r_rd_frame <= mem_frame[rd_addr];
            r_rd_pages <= mem_pages[rd_addr];
        end
    end

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // add region: clamp away page zero, round the base up to a page
    logic [63:0]        add_base, add_base_al;
    logic               add_unaligned, add_too_high, add_ignored;
    logic [FW-1:0]      add_frame, free_frame;
    logic [PAGES_W-1:0] add_pages;
    logic               tbl_full;
    logic [63:0]        free_base;

    always_comb begin
        add_base = 64'(i_address) & AddrMask;
        if (add_base < PAGE_BYTES) add_base = PAGE_BYTES;
        add_unaligned = |add_base[PAGE_SHIFT-1:0];
        add_too_high  = add_base > (AddrMask - PAGE_MASK);
        add_base_al   = add_unaligned ? ((add_base + PAGE_MASK) & ~PAGE_MASK) : add_base;
        add_frame     = add_base_al[FW+PAGE_SHIFT-1:PAGE_SHIFT];
        add_pages     = i_length_bytes[ADDR_W-1:PAGE_SHIFT];
        add_ignored   = !i_region_usable || (add_pages == '0)
                        || (add_unaligned && add_too_high);
        free_base     = 64'(i_address) & AddrMask;
        free_frame    = free_base[FW+PAGE_SHIFT-1:PAGE_SHIFT];
        tbl_full      = r_total >= CW'(MAX_EXTENTS);
    end

    // search compare and result address
    logic [PAGES_W:0]  diff;
    logic              hit;
    logic [CW-1:0]     idx_next, idx_prev;
    logic [63:0]       calc_sum, calc_shift;
    logic [ADDR_W-1:0] calc_addr;
    logic              alloc_start;

    always_comb begin
        diff       = {1'b0, r_rd_pages} - {1'b0, r_want};
        hit        = !diff[PAGES_W];
        idx_next   = r_idx + CW'(1);
        idx_prev   = r_idx - CW'(1);
        calc_sum   = 64'(r_hit_frame) + 64'(r_left);
        calc_shift = (calc_sum << PAGE_SHIFT) & AddrMask;
        calc_addr  = calc_shift[ADDR_W-1:0];
        alloc_start = (t_opcode'(i_opcode) == OP_ALLOC) && (i_page_count != '0)
                      && (r_total != '0);
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (fin) begin
            n_state = out_free ? S_IDLE : S_DONE;
        end else begin
            case (r_state)
                S_IDLE:   if (in_fire && alloc_start) n_state = S_SEARCH;
                S_SEARCH: if (hit) n_state = S_CALC;
                S_CALC:   n_state = S_SHIFT;
                S_SHIFT:  n_state = S_SHIFT;
                S_DONE:   n_state = S_DONE;
                default:  n_state = S_IDLE;
            endcase
        end
    end

    // datapath, memory control and result
    always_comb begin
        n_total      = r_total;
        n_idx        = r_idx;
        n_want       = r_want;
        n_left       = r_left;
        n_hit_frame  = r_hit_frame;
        n_hit_idx    = r_hit_idx;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        rd_en        = 1'b0;
        rd_addr      = '0;
        we_frame     = 1'b0;
        we_pages     = 1'b0;
        wr_addr      = r_total[IW-1:0];
        wr_frame     = add_frame;
        wr_pages     = add_pages;
        fin          = 1'b0;
        fin_addr     = '0;
        fin_status   = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (t_opcode'(i_opcode))
                        OP_ADD: begin
                            fin = 1'b1;
                            if (add_ignored) begin
                                fin_status = ST_IGNORED;
                            end else if (tbl_full) begin
                                fin_status = ST_FULL;
                            end else begin
                                we_frame = 1'b1;
                                we_pages = 1'b1;
                                n_total  = r_total + CW'(1);
                            end
                        end
                        OP_ALLOC: begin
                            if (alloc_start) begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_idx   = '0;
                                n_want  = i_page_count;
                            end else begin
                                fin        = 1'b1;
                                fin_status = ST_NOFIT;
                            end
                        end
                        OP_FREE: begin
                            fin      = 1'b1;
                            wr_frame = free_frame;
                            wr_pages = i_page_count;
                            if (i_page_count == '0) begin
                                fin_status = ST_IGNORED;
                            end else if (tbl_full) begin
                                fin_status = ST_FULL;
                            end else begin
                                we_frame = 1'b1;
                                we_pages = 1'b1;
                                n_total  = r_total + CW'(1);
                            end
                        end
                        default: begin
                            fin        = 1'b1;
                            fin_status = ST_IGNORED;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // read the next entry while the current one is compared
                rd_en   = 1'b1;
                rd_addr = idx_next[IW-1:0];
                if (hit) begin
                    n_left      = diff[PAGES_W-1:0];
                    n_hit_frame = r_rd_frame;
                    n_hit_idx   = r_idx[IW-1:0];
                end else if (idx_next >= r_total) begin
                    fin        = 1'b1;
                    fin_status = ST_NOFIT;
                end else begin
                    n_idx = idx_next;
                end
            end
            S_CALC: begin
                // read register still holds the entry after the hit
                if (r_left == '0) begin
                    n_idx        = CW'(r_hit_idx) + CW'(1);
                    n_res_addr   = calc_addr;
                    n_res_status = ST_OK;
                end else begin
                    we_pages = 1'b1;
                    wr_addr  = r_hit_idx;
                    wr_pages = r_left;
                    fin      = 1'b1;
                    fin_addr = calc_addr;
                end
            end
            S_SHIFT: begin
                // close up: entry idx moves down to idx-1
                if (r_idx < r_total) begin
                    we_frame = 1'b1;
                    we_pages = 1'b1;
                    wr_addr  = idx_prev[IW-1:0];
                    wr_frame = r_rd_frame;
                    wr_pages = r_rd_pages;
                    rd_en    = 1'b1;
                    rd_addr  = idx_next[IW-1:0];
                    n_idx    = idx_next;
                end else begin
                    n_total    = r_total - CW'(1);
                    fin        = 1'b1;
                    fin_addr   = r_res_addr;
                    fin_status = r_res_status;
                end
            end
            S_DONE: begin
                fin        = 1'b1;
                fin_addr   = r_res_addr;
                fin_status = r_res_status;
            end
            default: ;
        endcase

        if (fin) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_addr   = fin_addr;
                n_out_status = fin_status;
            end else begin
                n_res_addr   = fin_addr;
                n_res_status = fin_status;
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_want       <= n_want;
        r_left       <= n_left;
        r_hit_frame  <= n_hit_frame;
        r_hit_idx    <= n_hit_idx;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_status;

endmodule

### sv/pefa_checker.sv
// port-level checks for the page extent first-fit allocator, bound to the top level
// depends on pefa_pkg and page_extent_first_fit_allocator_unit

module pefa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [pefa_pkg::ADDR_W-1:0]   o_result_address,
    input logic [pefa_pkg::STATUS_W-1:0] o_status
);
    import pefa_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_result_address) && $stable(o_status))
        else $error("result changed while stalled");

    // only a successful allocate carries an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_result_address == '0)
        else $error("non-zero address on failed or non-allocate result");

    // the block leaves idle only on an input transfer
    a_ready_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && !i_in_valid |=> o_in_ready)
        else $error("input ready dropped without a transfer");

    a_reset_state: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> o_in_ready && !o_out_valid)
        else $error("not idle after reset");

endmodule

bind page_extent_first_fit_allocator_unit pefa_checker u_pefa_checker (.*);

### verif/pefa_result_checker.sv
// result checker for the page extent first-fit allocator: mirrors the extent table,
// predicts each answer and compares every output transfer against it
// depends on pefa_pkg
`timescale 1ns / 1ps

module pefa_result_checker #(
    parameter int EXTENT_SLOTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [pefa_pkg::OP_W-1:0]     i_opcode,
    input  logic [pefa_pkg::ADDR_W-1:0]   i_address,
    input  logic [pefa_pkg::ADDR_W-1:0]   i_length_bytes,
    input  logic                          i_region_usable,
    input  logic [pefa_pkg::PAGES_W-1:0]  i_page_count,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [pefa_pkg::ADDR_W-1:0]   i_result_address,
    input  logic [pefa_pkg::STATUS_W-1:0] i_status,
    output int                            o_mismatches,
    output int                            o_outstanding,
    output int                            o_ok_seen,
    output int                            o_nofit_seen,
    output int                            o_full_seen,
    output int                            o_ignored_seen
);
    import pefa_pkg::*;

    localparam int FRAME_W = ADDR_W - PAGE_SHIFT;
    localparam logic [63:0] ADDR_TOP = (64'd1 << ADDR_W) - 64'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        t_status           status;
    } t_alloc_answer;

    // mirror of the free extent table
    logic [FRAME_W-1:0] span_base  [EXTENT_SLOTS];
    logic [PAGES_W-1:0] span_pages [EXTENT_SLOTS];
    int                 span_count;

    t_alloc_answer answers_due [$];

    function automatic t_status push_extent(logic [FRAME_W-1:0] frame,
                                            logic [PAGES_W-1:0] pages);
        if (span_count >= EXTENT_SLOTS)
            return ST_FULL;
        span_base[span_count]  = frame;
        span_pages[span_count] = pages;
        span_count++;
        return ST_OK;
    endfunction

    function automatic t_status admit_region(logic [ADDR_W-1:0] base_in,
                                             logic [ADDR_W-1:0] len,
                                             logic usable);
        logic [63:0]        base;
        logic [PAGES_W-1:0] n_pages;
        n_pages = len[ADDR_W-1:PAGE_SHIFT];
        if (!usable || n_pages == 0)
            return ST_IGNORED;
        base = {{(64-ADDR_W){1'b0}}, base_in};
        // a base in page zero is raised to page one
        if (base < PAGE_BYTES)
            base = PAGE_BYTES;
        if ((base & PAGE_MASK) != 0) begin
            if (base > ADDR_TOP - PAGE_MASK)
                return ST_IGNORED;
            base = (base + PAGE_MASK) & ~PAGE_MASK;
        end
        return push_extent(base[ADDR_W-1:PAGE_SHIFT], n_pages);
    endfunction

    function automatic t_alloc_answer take_pages(logic [PAGES_W-1:0] want);
        t_alloc_answer ans;
        logic [63:0]   wide_pages;
        logic [63:0]   wide_base;
        logic [63:0]   left;
        logic [63:0]   top;
        int            hit;
        int            i;
        ans.addr   = '0;
        ans.status = ST_NOFIT;
        if (want == 0)
            return ans;
        hit = -1;
        for (i = 0; i < span_count; i++) begin
            if (hit < 0 && span_pages[i] >= want)
                hit = i;
        end
        if (hit < 0)
            return ans;
        wide_pages = 64'(span_pages[hit]);
        wide_base  = 64'(span_base[hit]);
        left       = wide_pages - 64'(want);
        // pages come off the top end; the sum may leave the address range and wrap
        top        = (wide_base + left) << PAGE_SHIFT;
        ans.addr   = top[ADDR_W-1:0];
        ans.status = ST_OK;
        if (left == 0) begin
            for (i = hit; i + 1 < span_count; i++) begin
                span_base[i]  = span_base[i + 1];
                span_pages[i] = span_pages[i + 1];
            end
            span_count--;
        end else begin
            span_pages[hit] = left[PAGES_W-1:0];
        end
        return ans;
    endfunction

    function automatic t_alloc_answer serve_request(t_opcode op,
                                                    logic [ADDR_W-1:0] addr,
                                                    logic [ADDR_W-1:0] len,
                                                    logic usable,
                                                    logic [PAGES_W-1:0] pages);
        t_alloc_answer ans;
        ans.addr   = '0;
        ans.status = ST_IGNORED;
        case (op)
            OP_ADD: begin
                ans.status = admit_region(addr, len, usable);
            end
            OP_ALLOC: begin
                ans = take_pages(pages);
            end
            OP_FREE: begin
                // low 12 bits of a freed address are dropped
                if (pages != 0)
                    ans.status = push_extent(addr[ADDR_W-1:PAGE_SHIFT], pages);
            end
            default: begin
                ans.status = ST_IGNORED;
            end
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_answer due;
        if (!i_rst_n) begin
            span_count = 0;
            answers_due.delete();
            o_mismatches   = 0;
            o_outstanding  = 0;
            o_ok_seen      = 0;
            o_nofit_seen   = 0;
            o_full_seen    = 0;
            o_ignored_seen = 0;
        end else begin
            // a result never leaves in the cycle of its own request, so retire first
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: result transfer with nothing outstanding: address %h status %0d",
                             $time, i_result_address, i_status);
                    o_mismatches++;
                end else begin
                    due = answers_due.pop_front();
                    if (i_result_address !== due.addr) begin
                        $display("%0t: result address mismatch: expected %h, actual %h",
                                 $time, due.addr, i_result_address);
                        o_mismatches++;
                    end
                    if (i_status !== due.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, due.status, i_status);
                        o_mismatches++;
                    end
                    case (due.status)
                        ST_OK:    o_ok_seen++;
                        ST_NOFIT: o_nofit_seen++;
                        ST_FULL:  o_full_seen++;
                        default:  o_ignored_seen++;
                    endcase
                end
            end
            if (i_in_valid && i_in_ready)
                answers_due.push_back(serve_request(t_opcode'(i_opcode), i_address,
                                                    i_length_bytes, i_region_usable,
                                                    i_page_count));
            o_outstanding = answers_due.size();
        end
    end

endmodule

### verif/tb.sv
// testbench top for the page extent first-fit allocator: clock, reset, request stimulus
// and result back-pressure; the verdict comes from the mismatch count of the checker
// depends on pefa_pkg, page_extent_first_fit_allocator_unit and pefa_result_checker
`timescale 1ns / 1ps

module tb;
    import pefa_pkg::*;

    localparam int EXTENT_SLOTS = 64;
    localparam int CYCLE_LIMIT  = 500000;
    localparam logic [ADDR_W-1:0]  ADDR_ONES  = '1;
    localparam logic [PAGES_W-1:0] PAGES_ONES = '1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     opcode = '0;
    logic [ADDR_W-1:0]   address = '0;
    logic [ADDR_W-1:0]   length_bytes = '0;
    logic                region_usable = 1'b0;
    logic [PAGES_W-1:0]  page_count = '0;
    logic                out_valid;
    logic                out_ready = 1'b1;
    logic [ADDR_W-1:0]   result_address;
    logic [STATUS_W-1:0] status;

    int mismatches;
    int outstanding;
    int ok_seen;
    int nofit_seen;
    int full_seen;
    int ignored_seen;
    int requests_sent = 0;
    int cycle_count = 0;
    bit quiet_tail = 1'b0;

    always #5 clk = ~clk;

    page_extent_first_fit_allocator_unit #(
        .MAX_EXTENTS (EXTENT_SLOTS),
        .ADDR_BITS   (ADDR_W)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_address        (address),
        .i_length_bytes   (length_bytes),
        .i_region_usable  (region_usable),
        .i_page_count     (page_count),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_result_address (result_address),
        .o_status         (status)
    );

    pefa_result_checker #(
        .EXTENT_SLOTS (EXTENT_SLOTS)
    ) result_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_address        (address),
        .i_length_bytes   (length_bytes),
        .i_region_usable  (region_usable),
        .i_page_count     (page_count),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_result_address (result_address),
        .i_status         (status),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding),
        .o_ok_seen        (ok_seen),
        .o_nofit_seen     (nofit_seen),
        .o_full_seen      (full_seen),
        .o_ignored_seen   (ignored_seen)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side back-pressure in short bursts
    initial begin
        int stall_len;
        forever begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                stall_len = $urandom_range(1, 4);
                out_ready = 1'b0;
                repeat (stall_len) @(negedge clk);
                out_ready = 1'b1;
            end
        end
    end

    function automatic logic [63:0] wide_random();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        logic [63:0] r;
        r = wide_random();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ADDR_ONES;
            2, 3:    return ADDR_W'(r[13:0]);
            4, 5:    return {r[ADDR_W-1:PAGE_SHIFT], 12'h000};
            default: return r[ADDR_W-1:0];
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_length();
        logic [63:0]       r;
        logic [ADDR_W-1:0] len;
        r = wide_random();
        case ($urandom_range(0, 9))
            0:       return ADDR_W'(r[11:0]);
            1:       return ADDR_ONES;
            2:       return r[ADDR_W-1:0];
            default: begin
                // mostly a handful of pages so extents empty and the table turns over
                len = ADDR_W'($urandom_range(1, 12));
                len = (len << PAGE_SHIFT) | ADDR_W'(r[11:0]);
                return len;
            end
        endcase
    endfunction

    function automatic logic [PAGES_W-1:0] pick_pages();
        logic [63:0] r;
        r = wide_random();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return PAGES_ONES;
            2, 3:    return r[PAGES_W-1:0];
            default: return PAGES_W'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic hold_input(int cycles);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_request(t_opcode op, logic [ADDR_W-1:0] addr,
                                logic [ADDR_W-1:0] len, logic usable,
                                logic [PAGES_W-1:0] pages);
        if (!quiet_tail && $urandom_range(0, 4) == 0)
            hold_input($urandom_range(1, 4));
        @(negedge clk);
        in_valid      = 1'b1;
        opcode        = op;
        address       = addr;
        length_bytes  = len;
        region_usable = usable;
        page_count    = pages;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests_sent++;
    endtask

    // grow_pct weights add and free against allocate
    task automatic send_random(int grow_pct);
        int          pick;
        logic [63:0] r1;
        logic [63:0] r2;
        pick = $urandom_range(0, 99);
        r1 = wide_random();
        r2 = wide_random();
        if (pick < 3) begin
            send_request(OP_RSVD, r1[ADDR_W-1:0], r2[ADDR_W-1:0], r1[63], r2[PAGES_W-1:0]);
        end else if (pick < 3 + grow_pct) begin
            if (pick % 2 == 0)
                send_request(OP_ADD, pick_address(), pick_length(),
                             $urandom_range(0, 9) != 0, r2[PAGES_W-1:0]);
            else
                send_request(OP_FREE, pick_address(), r1[ADDR_W-1:0], r1[63], pick_pages());
        end else begin
            send_request(OP_ALLOC, r1[ADDR_W-1:0], r2[ADDR_W-1:0], r1[63], pick_pages());
        end
    endtask

    initial begin
        int          episode_len [5];
        int          episode_grow [5];
        int          ep;
        int          n;
        int          settle;
        logic [63:0] r;

        episode_len  = '{120, 110, 120, 110, 90};
        episode_grow = '{92, 10, 92, 10, 50};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table, zero-page requests and regions that must be ignored
        send_request(OP_ALLOC, '0, '0, 1'b0, 40'd1);
        send_request(OP_ALLOC, '0, '0, 1'b0, '0);
        send_request(OP_ADD, 52'h2000, 52'h4000, 1'b0, '0);
        send_request(OP_ADD, 52'h3000, 52'h0fff, 1'b1, '0);
        // base in page zero is raised, unaligned base is rounded up
        send_request(OP_ADD, '0, 52'h10000, 1'b1, '0);
        send_request(OP_ADD, 52'h12345, 52'h5000, 1'b1, '0);
        // unaligned base in the top page cannot be rounded up
        send_request(OP_ADD, ADDR_ONES, 52'h2000, 1'b1, '0);
        send_request(OP_ADD, {ADDR_ONES[ADDR_W-1:PAGE_SHIFT], 12'h000}, ADDR_ONES, 1'b1, '0);
        send_request(OP_FREE, 52'h76543, '0, 1'b0, '0);
        send_request(OP_FREE, 52'h76543, '0, 1'b0, 40'd3);
        send_request(OP_FREE, ADDR_ONES, ADDR_ONES, 1'b1, PAGES_ONES);
        r = wide_random();
        send_request(OP_RSVD, r[ADDR_W-1:0], r[63:12], r[0], r[PAGES_W-1:0]);
        // exact fit empties the first extent, partial fit then emptying the next
        send_request(OP_ALLOC, '0, '0, 1'b0, 40'd16);
        send_request(OP_ALLOC, '0, '0, 1'b0, 40'd2);
        send_request(OP_ALLOC, '0, '0, 1'b0, 40'd3);
        // top extent: frame plus remainder wraps past the address range
        send_request(OP_ALLOC, '0, '0, 1'b0, 40'd1);
        send_request(OP_ALLOC, '0, '0, 1'b0, PAGES_ONES);
        send_request(OP_ALLOC, '0, '0, 1'b0, 40'd4);
        send_request(OP_ADD, 52'h1000, ADDR_ONES, 1'b1, '0);
        send_request(OP_ADD, 52'h0fff, 52'h1000, 1'b1, '0);
        send_request(OP_ALLOC, '0, '0, 1'b0, PAGES_ONES);
        send_request(OP_ALLOC, '0, '0, 1'b0, PAGES_ONES);
        send_request(OP_RSVD, ADDR_ONES, ADDR_ONES, 1'b1, PAGES_ONES);

        // alternate filling the table past full and draining it
        for (ep = 0; ep < 5; ep++) begin
            if (ep == 4)
                quiet_tail = 1'b1;
            for (n = 0; n < episode_len[ep]; n++)
                send_random(episode_grow[ep]);
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(posedge clk);
        settle = EXTENT_SLOTS + 8;
        repeat (settle) @(posedge clk);

        $display("%0d requests accepted; answers: %0d ok, %0d no fit, %0d table full, %0d ignored",
                 requests_sent, ok_seen, nofit_seen, full_seen, ignored_seen);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, outstanding);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
